// ----- rtl/core/ops_pkg.sv -----
// ops_pkg: shared types, constants and tables for the orbit position block.
// Used by the CORDIC unit, the shared multiplier and the top level.
// Depends on nothing.
package ops_pkg;

   // Number formats
   localparam int FracBits   = 8;
   localparam int RadiusW    = 15;
   localparam int AngleW     = 15;
   localparam int DeltaW     = 16;
   localparam int PosW       = 16;
   localparam int PhaseW     = 32;
   localparam int TrigW      = 32;
   localparam int MulW       = 32;
   localparam int ProdW      = 2 * MulW;

   // One full turn in 1/64 degree units is 45 * 2^9.
   localparam int TurnUnits  = 360 * 64;
   localparam int TurnOdd    = 45;
   localparam int TurnPow    = 9;

   // phase = floor((ang * 2^23 + 22) / 45) = ang * PhaseMulInt
   //       + floor((ang * PhaseMulRem + PhaseBias) / 45)
   localparam int PhaseMulInt = (1 << (PhaseW - TurnPow)) / TurnOdd;
   localparam int PhaseMulRem = (1 << (PhaseW - TurnPow)) % TurnOdd;
   localparam int PhaseBias   = (TurnUnits / 2) >> TurnPow;
   localparam int RemW        = 20;
   localparam int QuotW       = 14;
   localparam int RecipShift  = 26;
   localparam int RecipOdd    = (1 << RecipShift) / TurnOdd;

   // Reset values
   localparam int MinRadiusReset = (2 << FracBits) % (1 << RadiusW);
   localparam int MaxRadiusReset = (64 << FracBits) % (1 << RadiusW);
   localparam int RadiusReset    = (16 << FracBits) % (1 << RadiusW);
   localparam int PitchReset     = 90 * 64;
   localparam int AzimuthReset   = 0;

   // CORDIC
   localparam int CordicIterations = 16;
   localparam int AtanLen          = 24;
   localparam int CordicW          = 34;
   localparam int CordicGain       = 652032874;

   // Configuration register indexes
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CsrMinRadius = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrMaxRadius = 1'b1;

   typedef struct packed {
      logic                     done;
      logic signed [TrigW-1:0]  sin_q30;
      logic signed [TrigW-1:0]  cos_q30;
   } cordic_res_type;

   // Arctangent of 2^-i, 2^32 units per turn
   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5341269;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/ops_if.sv -----
// ops_if: valid/ready channel interfaces for the orbit position block.
// Depends on nothing; widths match ops_pkg.
interface ops_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] delta_pitch;
   logic signed [15:0] delta_azimuth;
   logic signed [15:0] delta_radius;

   modport source(output valid, delta_pitch, delta_azimuth, delta_radius, input ready);
   modport sink(input valid, delta_pitch, delta_azimuth, delta_radius, output ready);
endinterface

interface ops_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic [14:0]        pitch_now;
   logic [14:0]        azimuth_now;

   modport source(output valid, pos_x, pos_y, pos_z, pitch_now, azimuth_now, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, pitch_now, azimuth_now, output ready);
endinterface

// ----- rtl/core/ops_mult.sv -----
// ops_mult: shared 32x32 signed multiplier with a registered product.
// Depends on ops_pkg.
module ops_mult (
   input  logic                             clock,
   input  logic signed [ops_pkg::MulW-1:0]  mul_a,
   input  logic signed [ops_pkg::MulW-1:0]  mul_b,
   output logic signed [ops_pkg::ProdW-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ----- rtl/core/ops_cordic.sv -----
// ops_cordic: rotation-mode CORDIC, one micro-rotation per cycle.
// Folds the phase into [-90, 90] degrees and fixes the sign at the output.
// Depends on ops_pkg.
module ops_cordic #(
   parameter int CORDIC_ITERATIONS = ops_pkg::CordicIterations
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ops_pkg::PhaseW-1:0]        phase,
   output ops_pkg::cordic_res_type           res
);

   localparam int NumIter = (CORDIC_ITERATIONS < ops_pkg::AtanLen) ?
                            CORDIC_ITERATIONS : ops_pkg::AtanLen;
   localparam int IterW   = $clog2(NumIter);
   localparam int W       = ops_pkg::CordicW;

   localparam logic signed [W-1:0] QuarterTurn = W'(64'sd1 <<< 30);
   localparam logic signed [W-1:0] HalfTurn    = W'(64'sd1 <<< 31);
   localparam logic signed [W-1:0] GainInit    = W'(ops_pkg::CordicGain);
   localparam logic [IterW-1:0]    LastIter    = IterW'(NumIter - 1);

   logic signed [W-1:0] x_ff, y_ff, z_ff;
   logic                neg_ff, busy_ff, done_ff;
   logic [IterW-1:0]    iter_ff;

   logic signed [W-1:0] z_raw, z_fold, dx, dy, at;
   logic                neg_in;

   // Fold the phase into the CORDIC's convergence range
   always_comb begin
      z_raw  = {{(W - ops_pkg::PhaseW){phase[ops_pkg::PhaseW-1]}}, phase};
      z_fold = z_raw;
      neg_in = 1'b0;
      if (z_raw > QuarterTurn) begin
         z_fold = z_raw - HalfTurn;
         neg_in = 1'b1;
      end else if (z_raw < -QuarterTurn) begin
         z_fold = z_raw + HalfTurn;
         neg_in = 1'b1;
      end
   end

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = $signed({{(W - 30){1'b0}}, ops_pkg::atan_turn(5'(iter_ff))});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         // Flag the cycle after the last micro-rotation
         done_ff <= busy_ff && !start && (iter_ff == LastIter);
         if (start) begin
            x_ff    <= GainInit;
            y_ff    <= '0;
            z_ff    <= z_fold;
            neg_ff  <= neg_in;
            iter_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!z_ff[W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            if (iter_ff == LastIter) begin
               busy_ff <= 1'b0;
            end else begin
               iter_ff <= iter_ff + 1'b1;
            end
         end
      end
   end

   logic signed [W-1:0] sin_full, cos_full;
   assign sin_full = neg_ff ? -y_ff : y_ff;
   assign cos_full = neg_ff ? -x_ff : x_ff;
   assign res      = {done_ff, sin_full[ops_pkg::TrigW-1:0], cos_full[ops_pkg::TrigW-1:0]};

endmodule

// ----- rtl/core/orbit_position_spherical.sv -----
// orbit_position_spherical: keeps a point on an orbit in spherical form and
// returns its Cartesian position for every update transfer.
// req_if (sink): signed deltas of pitch, azimuth (1/64 degree) and radius
//   (8 fractional bits). One transfer is taken only while the sequencer idles.
// rsp_if (source): pos_x/pos_y/pos_z (8 fractional bits, saturated to 16 bits)
//   and the wrapped angles. The result sits in an output register until the
//   receiver takes it; a stalled receiver holds only the final load, so the
//   next request is already accepted and worked on meanwhile.
// csr_*: write min_radius (index 0) and max_radius (index 1), one per cycle.
// Each result is computed by the one CORDIC unit, which is run once for each
//   angle, and by the one 32x32 multiplier shared by the phase scaling and the
//   four position products. The sequencer takes the next request only after
//   the current result has loaded into the output register.
// Reset: pitch 90 degrees, azimuth 0, radius 16.0, clamps 2.0 and 64.0; the
//   output channel is empty and the block is ready on the cycle after reset.
// Depends on ops_pkg, ops_if, ops_cordic and ops_mult.
module orbit_position_spherical #(
   parameter int CORDIC_ITERATIONS = ops_pkg::CordicIterations
) (
   input  logic                                clock,
   input  logic                                reset,
   ops_req_if.sink                             req_if,
   ops_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [ops_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [ops_pkg::RadiusW-1:0]         csr_wdata
);

   localparam int RW = ops_pkg::RadiusW;
   localparam int AW = ops_pkg::AngleW;
   localparam int SW = AW + 3;
   localparam int PW = ops_pkg::ProdW;
   localparam int MW = ops_pkg::MulW;
   localparam int TW = ops_pkg::TrigW;

   localparam logic signed [SW-1:0] Turn = SW'(ops_pkg::TurnUnits);
   localparam logic signed [PW-1:0] Half15 = PW'(64'sd1 <<< 14);
   localparam logic signed [PW-1:0] Half30 = PW'(64'sd1 <<< 29);
   localparam logic signed [PW-1:0] Half45 = PW'(64'sd1 <<< 44);
   localparam logic signed [PW-1:0] PosMax = PW'(32767);
   localparam logic signed [PW-1:0] PosMin = -PW'(32768);

   typedef enum logic [3:0] {
      S_IDLE, S_WRAP, S_PH_MUL1, S_PH_MUL2, S_PH_FIX, S_CLOAD, S_CORDIC,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
   } state_type;

   state_type state_ff;

   // Architectural state and configuration
   logic [RW-1:0] radius_ff, min_ff, max_ff;
   logic [AW-1:0] pitch_ff, az_ff;

   // Working registers
   logic signed [SW-1:0]      psum_ff, asum_ff;
   logic                      sel_ff;
   logic [ops_pkg::RemW-1:0]  v_ff;
   logic [ops_pkg::PhaseW-1:0] base_ff;
   logic [ops_pkg::QuotW-1:0] q_ff;
   logic signed [TW-1:0]      sp_ff, cp_ff, sa_ff, ca_ff, t_ff;
   logic signed [15:0]        px_ff, py_ff, pz_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic signed [15:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [AW-1:0]             rsp_pitch_ff, rsp_az_ff;

   // Shared units
   logic signed [MW-1:0]      mul_a, mul_b;
   logic signed [PW-1:0]      prod_ff;
   logic                      cordic_start;
   logic [ops_pkg::PhaseW-1:0] phase_in;
   ops_pkg::cordic_res_type   cres;

   ops_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   ops_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .phase (phase_in),
      .res   (cres)
   );

   function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
      logic signed [15:0] r;
      if (v > PosMax) begin
         r = 16'sh7FFF;
      end else if (v < PosMin) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Radius update: test the low clamp first, then the high one
   logic signed [RW+1:0] rsum;
   logic [RW-1:0]        radius_in;
   always_comb begin
      rsum = $signed({2'b00, radius_ff}) +
             $signed({req_if.delta_radius[15], req_if.delta_radius});
      if (rsum < $signed({2'b00, min_ff})) begin
         radius_in = min_ff;
      end else if (rsum > $signed({2'b00, max_ff})) begin
         radius_in = max_ff;
      end else begin
         radius_in = rsum[RW-1:0];
      end
   end

   // Angle wrap: one add or subtract of a full turn per cycle
   logic signed [SW-1:0] psum_in, asum_in;
   logic                 p_ok, a_ok;
   always_comb begin
      p_ok = !psum_ff[SW-1] && (psum_ff < Turn);
      a_ok = !asum_ff[SW-1] && (asum_ff < Turn);
      if (psum_ff[SW-1]) begin
         psum_in = psum_ff + Turn;
      end else if (!p_ok) begin
         psum_in = psum_ff - Turn;
      end else begin
         psum_in = psum_ff;
      end
      if (asum_ff[SW-1]) begin
         asum_in = asum_ff + Turn;
      end else if (!a_ok) begin
         asum_in = asum_ff - Turn;
      end else begin
         asum_in = asum_ff;
      end
   end

   // Phase scaling: remainder correction of the reciprocal quotient
   logic [AW-1:0]              ang;
   logic [ops_pkg::QuotW-1:0]  qa;
   logic [ops_pkg::RemW-1:0]   rem;
   logic [ops_pkg::QuotW-1:0]  q_in;
   always_comb begin
      ang  = sel_ff ? az_ff : pitch_ff;
      qa   = prod_ff[ops_pkg::RecipShift +: ops_pkg::QuotW];
      rem  = v_ff - ops_pkg::RemW'(qa) * ops_pkg::RemW'(ops_pkg::TurnOdd);
      q_in = (rem >= ops_pkg::RemW'(ops_pkg::TurnOdd)) ? qa + 1'b1 : qa;
      phase_in     = base_ff + ops_pkg::PhaseW'(q_ff);
      cordic_start = (state_ff == S_CLOAD);
   end

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PH_MUL1: begin
            mul_a = $signed(MW'(ang));
            mul_b = MW'(ops_pkg::PhaseMulInt);
         end
         S_PH_MUL2: begin
            mul_a = $signed(MW'(v_ff));
            mul_b = MW'(ops_pkg::RecipOdd);
         end
         S_M1: begin
            mul_a = $signed(MW'(radius_ff));
            mul_b = cp_ff;
         end
         S_M2: begin
            mul_a = $signed(MW'(radius_ff));
            mul_b = sp_ff;
         end
         S_M4: begin
            mul_a = t_ff;
            mul_b = sa_ff;
         end
         S_M5: begin
            mul_a = t_ff;
            mul_b = ca_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   logic signed [PW-1:0] rnd15, rnd30, rnd45;
   assign rnd15 = (prod_ff + Half15) >>> 15;
   assign rnd30 = (prod_ff + Half30) >>> 30;
   assign rnd45 = (prod_ff + Half45) >>> 45;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RW'(ops_pkg::RadiusReset);
         pitch_ff     <= AW'(ops_pkg::PitchReset);
         az_ff        <= AW'(ops_pkg::AzimuthReset);
         min_ff       <= RW'(ops_pkg::MinRadiusReset);
         max_ff       <= RW'(ops_pkg::MaxRadiusReset);
         sel_ff       <= 1'b0;
      end else begin
         // Configuration writes
         if (csr_we) begin
            case (csr_index)
               ops_pkg::CsrMinRadius: min_ff <= csr_wdata;
               ops_pkg::CsrMaxRadius: max_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Drop the result once the receiver takes it, unless a new one loads
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  radius_ff <= radius_in;
                  psum_ff   <= $signed({3'b000, pitch_ff}) +
                               $signed({{2{req_if.delta_pitch[15]}}, req_if.delta_pitch});
                  asum_ff   <= $signed({3'b000, az_ff}) +
                               $signed({{2{req_if.delta_azimuth[15]}}, req_if.delta_azimuth});
                  state_ff  <= S_WRAP;
               end
            end
            S_WRAP: begin
               if (p_ok && a_ok) begin
                  pitch_ff <= psum_ff[AW-1:0];
                  az_ff    <= asum_ff[AW-1:0];
                  sel_ff   <= 1'b0;
                  state_ff <= S_PH_MUL1;
               end else begin
                  psum_ff <= psum_in;
                  asum_ff <= asum_in;
               end
            end
            S_PH_MUL1: begin
               // Fractional part of the turn scaling, exact in 20 bits
               v_ff     <= ops_pkg::RemW'(ang) * ops_pkg::RemW'(ops_pkg::PhaseMulRem) +
                           ops_pkg::RemW'(ops_pkg::PhaseBias);
               state_ff <= S_PH_MUL2;
            end
            S_PH_MUL2: begin
               base_ff  <= prod_ff[ops_pkg::PhaseW-1:0];
               state_ff <= S_PH_FIX;
            end
            S_PH_FIX: begin
               q_ff     <= q_in;
               state_ff <= S_CLOAD;
            end
            S_CLOAD: begin
               state_ff <= S_CORDIC;
            end
            S_CORDIC: begin
               if (cres.done) begin
                  if (!sel_ff) begin
                     sp_ff    <= cres.sin_q30;
                     cp_ff    <= cres.cos_q30;
                     sel_ff   <= 1'b1;
                     state_ff <= S_PH_MUL1;
                  end else begin
                     sa_ff    <= cres.sin_q30;
                     ca_ff    <= cres.cos_q30;
                     state_ff <= S_M1;
                  end
               end
            end
            S_M1: begin
               state_ff <= S_M2;
            end
            S_M2: begin
               py_ff    <= sat16(rnd30);
               state_ff <= S_M3;
            end
            S_M3: begin
               t_ff     <= rnd15[TW-1:0];
               state_ff <= S_M4;
            end
            S_M4: begin
               state_ff <= S_M5;
            end
            S_M5: begin
               px_ff    <= sat16(rnd45);
               state_ff <= S_M6;
            end
            S_M6: begin
               pz_ff    <= sat16(rnd45);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= px_ff;
                  rsp_y_ff     <= py_ff;
                  rsp_z_ff     <= pz_ff;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_az_ff    <= az_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pos_x       = rsp_x_ff;
   assign rsp_if.pos_y       = rsp_y_ff;
   assign rsp_if.pos_z       = rsp_z_ff;
   assign rsp_if.pitch_now   = rsp_pitch_ff;
   assign rsp_if.azimuth_now = rsp_az_ff;

endmodule
